// ===== design/bsd_pkg.sv =====
package bsd_pkg;

   localparam int BlockSize       = 32;
   localparam int GroupsPerBlock  = BlockSize / 8;
   localparam int GroupIndexWidth = $clog2(GroupsPerBlock);
   localparam int LanesPerGroup   = 4;
   localparam int GroupSumWidth   = 15;
   localparam int BlockSumWidth   = 17;
   localparam int ScaleWidth      = 32;
   localparam int ProductWidth    = 64;
   localparam int ScaleProdWidth  = 48;
   localparam int AccWidth        = 64;
   localparam int FracBits        = 16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_SUM,
      ST_TERM,
      ST_ACC
   } state_type;

   typedef struct packed {
      logic load_in;
      logic do_mult;
      logic do_sum;
      logic load_scale;
      logic do_term;
      logic do_acc;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_busy;
   } status_type;

endpackage

// ===== design/bsd_req_if.sv =====
interface bsd_req_if;
   import bsd_pkg::*;

   logic                         valid;
   logic                         ready;
   logic        [31:0]           weight_bytes;
   logic        [31:0]           low_acts;
   logic        [31:0]           high_acts;
   logic signed [ScaleWidth-1:0] act_scale;
   logic signed [ScaleWidth-1:0] weight_scale;
   logic                         last_group;

   modport source (
      output valid, weight_bytes, low_acts, high_acts, act_scale, weight_scale, last_group,
      input  ready
   );
   modport sink (
      input  valid, weight_bytes, low_acts, high_acts, act_scale, weight_scale, last_group,
      output ready
   );
endinterface

// ===== design/bsd_rsp_if.sv =====
interface bsd_rsp_if;
   import bsd_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [AccWidth-1:0] dot_value;
   logic                       saturated;

   modport source (output valid, dot_value, saturated, input ready);
   modport sink (input valid, dot_value, saturated, output ready);
endinterface

// ===== design/bsd_ctrl.sv =====
module bsd_ctrl
   import bsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type                  state_ff, state_in;
   logic [GroupIndexWidth-1:0] group_ff, group_in;
   logic                       first_group;
   logic                       close_block;

   assign first_group = (group_ff == '0);
   assign close_block = (group_ff == GroupIndexWidth'(GroupsPerBlock - 1)) || status.last;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MULT;
         end
         ST_MULT: state_in = ST_SUM;
         ST_SUM: begin
            state_in = close_block ? ST_TERM : ST_IDLE;
         end
         ST_TERM: state_in = ST_ACC;
         ST_ACC: begin
            // A closing item that emits waits until the output register is free.
            if (!(status.last && status.out_busy)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.load_in = req_valid;
         end
         ST_MULT: cmd.do_mult = 1'b1;
         ST_SUM: begin
            cmd.do_sum     = 1'b1;
            cmd.load_scale = first_group;
         end
         ST_TERM: cmd.do_term = 1'b1;
         ST_ACC: begin
            if (!(status.last && status.out_busy)) begin
               cmd.do_acc = 1'b1;
               cmd.emit   = status.last;
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      group_in = group_ff;
      if (cmd.do_sum) begin
         group_in = close_block ? '0 : group_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         group_ff <= '0;
      end else begin
         state_ff <= state_in;
         group_ff <= group_in;
      end
   end

endmodule

// ===== design/bsd_datapath.sv =====
module bsd_datapath
   import bsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bsd_req_if.sink    req_if,
   bsd_rsp_if.source  rsp_if,
   input  cmd_type    cmd,
   output status_type status
);

   // Captured transaction.
   logic        [31:0]           weight_ff;
   logic        [31:0]           low_ff;
   logic        [31:0]           high_ff;
   logic signed [ScaleWidth-1:0] act_scale_ff;
   logic signed [ScaleWidth-1:0] weight_scale_ff;
   logic                         last_ff;

   logic signed [GroupSumWidth-1:0]  group_sum_ff, group_sum_in;
   logic signed [ProductWidth-1:0]   prod_ff;
   logic signed [ProductWidth-1:0]   prod_rounded;
   logic signed [BlockSumWidth-1:0]  block_sum_ff, block_sum_in;
   logic signed [ScaleProdWidth-1:0] scale_ff;
   logic signed [AccWidth-1:0]       term_ff;
   logic signed [AccWidth:0]         term_full;
   logic signed [AccWidth-1:0]       acc_ff, acc_in;
   logic signed [AccWidth:0]         acc_sum;
   logic                             clip_ff, clip_in;
   logic                             overflow;

   logic                       rsp_valid_ff;
   logic signed [AccWidth-1:0] rsp_value_ff;
   logic                       rsp_sat_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         weight_ff       <= req_if.weight_bytes;
         low_ff          <= req_if.low_acts;
         high_ff         <= req_if.high_acts;
         act_scale_ff    <= req_if.act_scale;
         weight_scale_ff <= req_if.weight_scale;
         last_ff         <= req_if.last_group;
      end
   end

   // A nibble minus 8 is the same nibble with its top bit flipped, read as signed.
   always_comb begin
      logic signed [3:0]  w_lo, w_hi;
      logic signed [7:0]  a_lo, a_hi;
      logic signed [11:0] p_lo, p_hi;
      group_sum_in = '0;
      for (int b = 0; b < LanesPerGroup; b++) begin
         w_lo = $signed(weight_ff[8*b +: 4] ^ 4'h8);
         w_hi = $signed(weight_ff[8*b+4 +: 4] ^ 4'h8);
         a_lo = $signed(low_ff[8*b +: 8]);
         a_hi = $signed(high_ff[8*b +: 8]);
         p_lo = 12'(w_lo * a_lo);
         p_hi = 12'(w_hi * a_hi);
         group_sum_in = group_sum_in + GroupSumWidth'(p_lo) + GroupSumWidth'(p_hi);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_mult) begin
         group_sum_ff <= group_sum_in;
         prod_ff      <= act_scale_ff * weight_scale_ff;
      end
   end

   // Round to nearest, ties toward plus infinity: add one half, then floor.
   assign prod_rounded = prod_ff + (ProductWidth'(1) <<< (FracBits - 1));

   always_comb begin
      block_sum_in = block_sum_ff;
      if (cmd.do_acc) begin
         block_sum_in = '0;
      end else if (cmd.do_sum) begin
         block_sum_in = block_sum_ff + BlockSumWidth'(group_sum_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_scale) scale_ff <= prod_rounded[FracBits +: ScaleProdWidth];
   end

   assign term_full = (AccWidth + 1)'(block_sum_ff * scale_ff);

   always_ff @(posedge clock) begin
      if (cmd.do_term) term_ff <= term_full[AccWidth-1:0];
   end

   assign acc_sum  = {acc_ff[AccWidth-1], acc_ff} + {term_ff[AccWidth-1], term_ff};
   assign overflow = acc_sum[AccWidth] ^ acc_sum[AccWidth-1];

   always_comb begin
      acc_in  = acc_ff;
      clip_in = clip_ff;
      if (cmd.do_acc) begin
         if (overflow) begin
            acc_in  = acc_sum[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}}
                                        : {1'b0, {(AccWidth-1){1'b1}}};
            clip_in = 1'b1;
         end else begin
            acc_in = acc_sum[AccWidth-1:0];
         end
         if (cmd.emit) begin
            acc_in  = '0;
            clip_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_sum_ff <= '0;
         acc_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         block_sum_ff <= block_sum_in;
         acc_ff       <= acc_in;
         clip_ff      <= clip_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_value_ff <= overflow ? (acc_sum[AccWidth] ? {1'b1, {(AccWidth-1){1'b0}}}
                                                       : {1'b0, {(AccWidth-1){1'b1}}})
                                  : acc_sum[AccWidth-1:0];
         rsp_sat_ff   <= clip_ff | overflow;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.dot_value = rsp_value_ff;
   assign rsp_if.saturated = rsp_sat_ff;

   assign status.last     = last_ff;
   assign status.out_busy = rsp_valid_ff & ~rsp_if.ready;

endmodule

// ===== design/int8_int4_block_scaled_dot.sv =====
// A closing transaction goes through the multiply, sum, scale-term and accumulate steps, and
// its result is registered onto rsp_if when the accumulate step emits. The controller takes
// one transaction at a time: a group inside a block skips the scale-term and accumulate
// steps, and a closing group stalls in accumulate while the output register holds a result.
// Reset (synchronous): clears group index, block sum, accumulator, clip flag and rsp valid.
module int8_int4_block_scaled_dot
   import bsd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   bsd_req_if.sink   req_if,
   bsd_rsp_if.source rsp_if
);

   cmd_type    cmd;
   status_type status;

   bsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsd_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cmd    (cmd),
      .status (status)
   );

endmodule
